// ===== design/mbet_pkg.sv =====
`default_nettype none

package mbet_pkg;

  // Fixed-point format of the complex plane coordinates.
  localparam int unsigned FRAC_BITS    = 28;
  localparam int unsigned PALETTE_SIZE = 16;
  localparam int unsigned COORD_BITS   = 12;

  localparam int unsigned ZW      = 32;                 // Q3.28 coordinate width
  localparam int unsigned PW      = 2 * ZW;             // full product width
  localparam int unsigned SQW     = PW - FRAC_BITS;     // width of a scaled square
  localparam int unsigned CNTW    = 16;                 // iteration counter width
  localparam int unsigned PIXW    = 12;                 // pixel coordinate port width
  localparam int unsigned IDXW    = $clog2(PALETTE_SIZE);
  localparam int unsigned CFG_AW  = 3;

  localparam logic [PIXW-1:0] PIX_MASK = PIXW'((64'(1) << COORD_BITS) - 64'(1));

  // Escape radius squared (4.0) in the scaled-square format.
  localparam logic signed [SQW:0] LIMIT4 = (SQW+1)'(64'(4) << FRAC_BITS);

  localparam logic signed [ZW-1:0] LEFT_REAL_RST = -32'sd805306368;
  localparam logic signed [ZW-1:0] TOP_IMAG_RST  = -32'sd402653184;
  localparam logic signed [ZW-1:0] STEP_REAL_RST = 32'sd1342177;
  localparam logic signed [ZW-1:0] STEP_IMAG_RST = 32'sd1342177;
  localparam logic [CNTW-1:0]      MAX_ITER_RST  = 16'd100;

  typedef enum logic [CFG_AW-1:0] {
    CFG_LEFT_REAL = 3'd0,
    CFG_TOP_IMAG  = 3'd1,
    CFG_STEP_REAL = 3'd2,
    CFG_STEP_IMAG = 3'd3,
    CFG_MAX_ITER  = 3'd4
  } cfg_idx_e;

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic logic signed [ZW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = PW'({1'b0, {(ZW-1){1'b1}}});
    lo = -hi - PW'(1);
    if (v > hi) begin
      return ZW'(hi);
    end else if (v < lo) begin
      return ZW'(lo);
    end else begin
      return ZW'(v);
    end
  endfunction

  // Palette entry as {red, green, blue}.
  function automatic logic [23:0] palette_rgb(input logic [IDXW-1:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = {8'd66,  8'd30,  8'd15};
      4'd1:    rgb = {8'd25,  8'd7,   8'd26};
      4'd2:    rgb = {8'd9,   8'd1,   8'd47};
      4'd3:    rgb = {8'd4,   8'd4,   8'd73};
      4'd4:    rgb = {8'd0,   8'd7,   8'd100};
      4'd5:    rgb = {8'd12,  8'd44,  8'd138};
      4'd6:    rgb = {8'd24,  8'd82,  8'd177};
      4'd7:    rgb = {8'd57,  8'd125, 8'd209};
      4'd8:    rgb = {8'd134, 8'd181, 8'd229};
      4'd9:    rgb = {8'd211, 8'd236, 8'd248};
      4'd10:   rgb = {8'd241, 8'd233, 8'd191};
      4'd11:   rgb = {8'd248, 8'd201, 8'd95};
      4'd12:   rgb = {8'd255, 8'd170, 8'd0};
      4'd13:   rgb = {8'd204, 8'd128, 8'd0};
      4'd14:   rgb = {8'd153, 8'd87,  8'd0};
      4'd15:   rgb = {8'd106, 8'd52,  8'd3};
      default: rgb = {8'd106, 8'd52,  8'd3};
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

// ===== design/mbet_mul.sv =====
`default_nettype none

module mbet_mul (
  input  wire logic                           clk_i,
  input  wire logic signed [mbet_pkg::ZW-1:0] a_i,
  input  wire logic signed [mbet_pkg::ZW-1:0] b_i,
  output logic signed [mbet_pkg::PW-1:0]      p_o
);
  import mbet_pkg::*;

  logic signed [PW-1:0] p_q;

  // One signed product per cycle, registered before any use.
  always_ff @(posedge clk_i) begin
    p_q <= PW'(a_i) * PW'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== design/mbet_div.sv =====
`default_nettype none

module mbet_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [mbet_pkg::CNTW-1:0]    num_i,
  input  wire logic [mbet_pkg::CNTW-1:0]    den_i,
  output logic                              done_o,
  output logic [mbet_pkg::IDXW-1:0]         quot_o
);
  import mbet_pkg::*;

  // Restoring division, min(floor(PALETTE_SIZE*num/den), 15), one bit a cycle.
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                sat_q, sat_d;
  logic [IDXW-1:0]     step_q, step_d;
  logic [CNTW-1:0]     rem_q, rem_d;
  logic [CNTW-1:0]     den_q, den_d;
  logic [IDXW-1:0]     quo_q, quo_d;
  logic [CNTW:0]       rem2;

  assign rem2 = {rem_q, 1'b0};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      sat_d  = (num_i >= den_i);
      step_d = '0;
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_d = CNTW'(rem2 - {1'b0, den_q});
        quo_d = {quo_q[IDXW-2:0], 1'b1};
      end else begin
        rem_d = CNTW'(rem2);
        quo_d = {quo_q[IDXW-2:0], 1'b0};
      end
      step_d = step_q + IDXW'(1);
      if (step_q == IDXW'(IDXW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sat_q  <= sat_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? {IDXW{1'b1}} : quo_q;

endmodule

`default_nettype wire

// ===== design/mandelbrot_escape_time_pixel.sv =====
// Escape-time engine for one pixel of the Mandelbrot set.
// Input channel (in_valid_i / in_ready_o) carries one pixel coordinate per beat.
// The point c is left_real + x*step_real, top_imag + y*step_imag in signed Q3.28.
// Output channel (out_valid_o / out_ready_i) carries one result per beat: the
// iteration count, the inside flag, the palette index and the palette RGB.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes one register
// per cycle and should only be used while the engine is idle.
// The point c is formed in states S_CR, S_CI and S_CSET; each iteration passes
// through S_TEST, S_ZI, S_SQR and S_SQI on the single shared 32x32 multiplier
// (cross product, then both squares), and the palette index comes from a
// four-step restoring divider. One pixel is in work at a time; in_ready_o is
// high only when the sequencer is idle.
// A finished result sits in the output register while the next pixel is
// accepted and computed; if the receiver still stalls when that next result is
// done, the sequencer waits with it until the output register frees up.
// Reset loads the default view and a limit of 100, and empties the output.
`default_nettype none

module mandelbrot_escape_time_pixel (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [mbet_pkg::PIXW-1:0]     pixel_x_i,
  input  wire logic [mbet_pkg::PIXW-1:0]     pixel_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [mbet_pkg::CNTW-1:0]          iter_count_o,
  output logic                               inside_res_o,
  output logic [mbet_pkg::IDXW-1:0]          palette_index_o,
  output logic [7:0]                         red_o,
  output logic [7:0]                         green_o,
  output logic [7:0]                         blue_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbet_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  wire logic [mbet_pkg::ZW-1:0]       cfg_data_i
);
  import mbet_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_CR   = 10'b00_0000_0010,
    S_CI   = 10'b00_0000_0100,
    S_CSET = 10'b00_0000_1000,
    S_TEST = 10'b00_0001_0000,
    S_ZI   = 10'b00_0010_0000,
    S_SQR  = 10'b00_0100_0000,
    S_SQI  = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic signed [ZW-1:0] left_real_q, top_imag_q, step_real_q, step_imag_q;
  logic [CNTW-1:0]      max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_real_q <= LEFT_REAL_RST;
      top_imag_q  <= TOP_IMAG_RST;
      step_real_q <= STEP_REAL_RST;
      step_imag_q <= STEP_IMAG_RST;
      max_iter_q  <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEFT_REAL: left_real_q <= cfg_data_i;
        CFG_TOP_IMAG:  top_imag_q  <= cfg_data_i;
        CFG_STEP_REAL: step_real_q <= cfg_data_i;
        CFG_STEP_IMAG: step_imag_q <= cfg_data_i;
        CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[CNTW-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers.
  logic [PIXW-1:0]       px_q, py_q;
  logic signed [ZW-1:0]  c_r_q, c_i_q, z_r_q, z_i_q;
  logic signed [SQW-1:0] sq_r_q, sq_i_q;
  logic [CNTW-1:0]       count_q;

  // Shared multiplier and its operand select.
  logic signed [ZW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  mul_p;

  mbet_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Palette divider.
  logic            div_start, div_done;
  logic [IDXW-1:0] div_quot;

  mbet_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (count_q),
    .den_i   (max_iter_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  logic signed [SQW:0]  mag2;
  logic                 keep_going;
  logic signed [ZW-1:0] z_r_next;
  logic signed [ZW-1:0] z_i_next;
  logic                 out_free;
  logic                 in_accept;
  logic                 out_load;

  assign in_accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_o || out_ready_i;
  assign out_load   = (state_q == S_OUT) && out_free;

  // Escape test on the squares left by the previous iteration.
  assign mag2       = (SQW+1)'(sq_r_q) + (SQW+1)'(sq_i_q);
  assign keep_going = (mag2 <= LIMIT4) && (count_q < max_iter_q);

  assign z_r_next = sat32(PW'(sq_r_q) - PW'(sq_i_q) + PW'(c_r_q));
  // The product register holds z_r*z_i; doubling folds into the shift.
  assign z_i_next = sat32((mul_p >>> (FRAC_BITS - 1)) + PW'(c_i_q));

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CR;
        end
      end
      S_CR: begin
        mul_a   = ZW'(px_q & PIX_MASK);
        mul_b   = step_real_q;
        state_d = S_CI;
      end
      S_CI: begin
        mul_a   = ZW'(py_q & PIX_MASK);
        mul_b   = step_imag_q;
        state_d = S_CSET;
      end
      S_CSET: begin
        state_d = S_TEST;
      end
      S_TEST: begin
        if (keep_going) begin
          mul_a   = z_r_q;
          mul_b   = z_i_q;
          state_d = S_ZI;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_ZI: begin
        mul_a   = z_r_q;
        mul_b   = z_r_q;
        state_d = S_SQR;
      end
      S_SQR: begin
        mul_a   = z_i_q;
        mul_b   = z_i_q;
        state_d = S_SQI;
      end
      S_SQI: begin
        state_d = S_TEST;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    case (state_q)
      S_CI: begin
        c_r_q <= sat32(PW'(left_real_q) + mul_p);
      end
      S_CSET: begin
        c_i_q   <= sat32(PW'(top_imag_q) + mul_p);
        z_r_q   <= '0;
        z_i_q   <= '0;
        sq_r_q  <= '0;
        sq_i_q  <= '0;
        count_q <= '0;
      end
      S_TEST: begin
        if (keep_going) begin
          z_r_q <= z_r_next;
        end
      end
      S_ZI: begin
        z_i_q <= z_i_next;
      end
      S_SQR: begin
        sq_r_q <= SQW'(mul_p >>> FRAC_BITS);
      end
      S_SQI: begin
        sq_i_q  <= SQW'(mul_p >>> FRAC_BITS);
        count_q <= count_q + CNTW'(1);
      end
      default: ;
    endcase
  end

  // Output register: holds a finished result until the receiver takes it.
  logic            out_valid_q;
  logic [CNTW-1:0] iter_count_q;
  logic            inside_q;
  logic [IDXW-1:0] pal_idx_q;
  logic [23:0]     rgb_q;
  logic            inside_d;
  logic [IDXW-1:0] pal_idx_d;

  // A pixel that ran to the limit always takes the last palette entry.
  assign inside_d  = (count_q == max_iter_q);
  assign pal_idx_d = inside_d ? {IDXW{1'b1}} : div_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      iter_count_q <= count_q;
      inside_q     <= inside_d;
      pal_idx_q    <= pal_idx_d;
      rgb_q        <= palette_rgb(pal_idx_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign iter_count_o    = iter_count_q;
  assign inside_res_o    = inside_q;
  assign palette_index_o = pal_idx_q;
  assign red_o           = rgb_q[23:16];
  assign green_o         = rgb_q[15:8];
  assign blue_o          = rgb_q[7:0];

  // Each pass through the last square stage counts exactly one iteration.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQI) |=> (count_q == $past(count_q) + CNTW'(1)))
    else $error("iteration count did not advance by one");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide wait");

  // Handing a result to the output register frees the input side next cycle.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && in_ready_o))
    else $error("result load did not show valid and return to idle");

  // An inside result always carries the last palette entry.
  a_inside_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |-> (palette_index_o == {IDXW{1'b1}}))
    else $error("inside pixel with a palette index below the top entry");

endmodule

`default_nettype wire

// ===== verif/mandelbrot_escape_time_pixel_test.sv =====
`timescale 1ns / 100ps

// The testbench feeds pixel coordinates into the escape-time engine, predicts the
// count, inside flag, palette index and color of every accepted pixel, and compares
// each result beat against the oldest prediction still waiting.
module mandelbrot_escape_time_pixel_test;
  import mbet_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // The receiver goes quiet for a long stretch once this many input beats are in.
  localparam int unsigned HOLD_AFTER     = 60;
  localparam int unsigned HOLD_CYCLES    = 1500;
  // Enough to cover one more pixel at the limit of 100.
  localparam int unsigned TAIL_CYCLES    = 500;
  localparam int unsigned PHASE_ITEMS    = 50;

  localparam int CFG_SPARE_FIRST = int'(CFG_MAX_ITER) + 1;
  localparam int CFG_SPARE_LAST  = (1 << CFG_AW) - 1;

  localparam logic [PIXW-1:0] COORD_MASK = PIXW'((1 << COORD_BITS) - 1);
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  // Handy Q3.28 values for the directed views.
  localparam logic [ZW-1:0] Q_ZERO    = 32'h0000_0000;
  localparam logic [ZW-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [ZW-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [ZW-1:0] Q_TWO     = 32'h2000_0000;
  localparam logic [ZW-1:0] Q_NEG_TWO = 32'hE000_0000;

  // Color table as {red, green, blue}, indexed by the palette index.
  localparam logic [23:0] SHADES [PALETTE_SIZE] = '{
    {8'd66,  8'd30,  8'd15},  {8'd25,  8'd7,   8'd26},
    {8'd9,   8'd1,   8'd47},  {8'd4,   8'd4,   8'd73},
    {8'd0,   8'd7,   8'd100}, {8'd12,  8'd44,  8'd138},
    {8'd24,  8'd82,  8'd177}, {8'd57,  8'd125, 8'd209},
    {8'd134, 8'd181, 8'd229}, {8'd211, 8'd236, 8'd248},
    {8'd241, 8'd233, 8'd191}, {8'd248, 8'd201, 8'd95},
    {8'd255, 8'd170, 8'd0},   {8'd204, 8'd128, 8'd0},
    {8'd153, 8'd87,  8'd0},   {8'd106, 8'd52,  8'd3}
  };

  typedef struct packed {
    logic [CNTW-1:0] count;
    logic            in_set;
    logic [IDXW-1:0] idx;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
  } pixel_res_t;

  // One directed probe: the view it needs, the pixel, whether the spare register
  // indexes get junk written first, and a hand-written result where one is given.
  typedef struct packed {
    logic [ZW-1:0]   left;
    logic [ZW-1:0]   top;
    logic [ZW-1:0]   step_r;
    logic [ZW-1:0]   step_i;
    logic [CNTW-1:0] limit;
    logic [PIXW-1:0] x;
    logic [PIXW-1:0] y;
    logic            junk;
    logic            typed;
    pixel_res_t      res;
  } probe_t;

  typedef enum int {
    VIEW_SET,     // window over the set itself, positive steps
    VIEW_MIRROR,  // window over the set, walked with negative steps
    VIEW_NOISE,   // every register random
    VIEW_FAST     // far right of the plane, where every point escapes at once
  } view_kind_e;

  localparam pixel_res_t ESC_FIRST = '{16'd1, 1'b0, 4'd0, 8'd66, 8'd30, 8'd15};

  localparam int PROBES = 18;
  localparam probe_t PROBE_TAB [PROBES] = '{
    // Reset view: the corner pixels lie far outside and escape on the first pass.
    '{LEFT_REAL_RST, TOP_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 16'd100,
      12'd0, 12'd0, 1'b0, 1'b1, ESC_FIRST},
    '{LEFT_REAL_RST, TOP_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 16'd100,
      12'd4095, 12'd4095, 1'b0, 1'b1, ESC_FIRST},
    // Near -1, deep inside, then near the edge; the second one follows junk writes
    // to the spare indexes, which must leave the view alone.
    '{LEFT_REAL_RST, TOP_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 16'd100,
      12'd400, 12'd300, 1'b0, 1'b0, '0},
    '{LEFT_REAL_RST, TOP_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 16'd100,
      12'd300, 12'd200, 1'b1, 1'b0, '0},
    '{LEFT_REAL_RST, TOP_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 16'd100,
      12'd500, 12'd250, 1'b0, 1'b0, '0},
    '{LEFT_REAL_RST, TOP_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 16'd7,
      12'd350, 12'd250, 1'b0, 1'b0, '0},
    // A limit of zero does no iteration and reports an inside pixel.
    '{LEFT_REAL_RST, TOP_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 16'd0,
      12'd400, 12'd300, 1'b0, 1'b1, '{16'd0, 1'b1, 4'd15, 8'd106, 8'd52, 8'd3}},
    // A limit of one always reaches the limit, so the index saturates.
    '{LEFT_REAL_RST, TOP_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 16'd1,
      12'd0, 12'd0, 1'b0, 1'b1, '{16'd1, 1'b1, 4'd15, 8'd106, 8'd52, 8'd3}},
    '{LEFT_REAL_RST, TOP_IMAG_RST, STEP_REAL_RST, STEP_IMAG_RST, 16'd1,
      12'd4095, 12'd4095, 1'b0, 1'b1, '{16'd1, 1'b1, 4'd15, 8'd106, 8'd52, 8'd3}},
    // The origin never moves, so the count runs to the limit.
    '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 16'd20,
      12'd4095, 12'd0, 1'b0, 1'b1, '{16'd20, 1'b1, 4'd15, 8'd106, 8'd52, 8'd3}},
    // At -2 the magnitude sits exactly on the escape radius every pass.
    '{Q_NEG_TWO, Q_ZERO, Q_ZERO, Q_ZERO, 16'd16,
      12'd123, 12'd456, 1'b0, 1'b0, '0},
    // Register extremes with the largest limit; the first two escape at once.
    '{Q_MIN, Q_MAX, Q_ZERO, Q_ZERO, 16'd65535,
      12'hAAA, 12'h555, 1'b0, 1'b1, ESC_FIRST},
    '{Q_MAX, Q_MIN, Q_ZERO, Q_ZERO, 16'd65535,
      12'h555, 12'hAAA, 1'b0, 1'b1, ESC_FIRST},
    '{Q_TWO, Q_ZERO, Q_ZERO, Q_ZERO, 16'd65535,
      12'd7, 12'd9, 1'b0, 1'b0, '0},
    // Extreme steps: the far pixel saturates c, the origin pixel stays inside.
    '{Q_ZERO, Q_ZERO, Q_MAX, Q_MIN, 16'd100,
      12'd4095, 12'd4095, 1'b0, 1'b1, ESC_FIRST},
    '{Q_ZERO, Q_ZERO, Q_MAX, Q_MIN, 16'd100,
      12'd0, 12'd0, 1'b0, 1'b1, '{16'd100, 1'b1, 4'd15, 8'd106, 8'd52, 8'd3}},
    '{Q_ZERO, Q_ZERO, Q_MAX, Q_MIN, 16'd100,
      12'd1, 12'd0, 1'b0, 1'b1, ESC_FIRST},
    '{Q_ZERO, Q_ZERO, Q_MAX, Q_MIN, 16'd100,
      12'd0, 12'd1, 1'b0, 1'b1, ESC_FIRST}
  };

  // The random part walks these views in order; the last one runs without idling.
  localparam int PHASES = 9;
  localparam view_kind_e PHASE_PLAN [PHASES] = '{
    VIEW_SET, VIEW_SET, VIEW_NOISE, VIEW_MIRROR, VIEW_FAST,
    VIEW_SET, VIEW_MIRROR, VIEW_NOISE, VIEW_SET
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [PIXW-1:0]   pixel_x_i   = '0;
  logic [PIXW-1:0]   pixel_y_i   = '0;
  logic              out_ready_i = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i   = '0;
  logic [ZW-1:0]     cfg_data_i  = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [CNTW-1:0]   iter_count_o;
  logic              inside_res_o;
  logic [IDXW-1:0]   palette_index_o;
  logic [7:0]        red_o;
  logic [7:0]        green_o;
  logic [7:0]        blue_o;

  // Our own copy of the view registers, updated whenever the bench writes them.
  logic signed [ZW-1:0] view_left   = LEFT_REAL_RST;
  logic signed [ZW-1:0] view_top    = TOP_IMAG_RST;
  logic signed [ZW-1:0] view_step_r = STEP_REAL_RST;
  logic signed [ZW-1:0] view_step_i = STEP_IMAG_RST;
  logic [CNTW-1:0]      iter_limit  = MAX_ITER_RST;

  // Results of pixels offered but not yet taken, and of pixels taken by the block.
  pixel_res_t  offered_results [$];
  pixel_res_t  awaited_results [$];
  int unsigned failures = 0;
  int unsigned beats_in = 0;
  bit          calm     = 1'b0;

  mandelbrot_escape_time_pixel i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .iter_count_o    (iter_count_o),
    .inside_res_o    (inside_res_o),
    .palette_index_o (palette_index_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) begin
      return Q_HI;
    end
    if (v < Q_LO) begin
      return Q_LO;
    end
    return v;
  endfunction

  // Escape-time count and color of one pixel under the current view. The squares
  // and the doubled cross product are floored by arithmetic shifts; both parts of
  // z are clamped to 32 bits after every pass.
  function automatic pixel_res_t escape_time(input logic [PIXW-1:0] x,
                                             input logic [PIXW-1:0] y);
    longint      c_r;
    longint      c_i;
    longint      z_r;
    longint      z_i;
    longint      sq_r;
    longint      sq_i;
    longint      cross_prod;
    longint      radius;
    int unsigned count;
    int unsigned idx;
    pixel_res_t  res;
    c_r    = clamp_q(longint'(view_left) + longint'(x & COORD_MASK) * longint'(view_step_r));
    c_i    = clamp_q(longint'(view_top) + longint'(y & COORD_MASK) * longint'(view_step_i));
    radius = longint'(4) << FRAC_BITS;
    z_r    = 0;
    z_i    = 0;
    sq_r   = 0;
    sq_i   = 0;
    count  = 0;
    while (sq_r + sq_i <= radius && count < iter_limit) begin
      cross_prod = z_r * z_i;
      z_i   = clamp_q((cross_prod >>> (FRAC_BITS - 1)) + c_i);
      z_r   = clamp_q(sq_r - sq_i + c_r);
      sq_r  = (z_r * z_r) >>> FRAC_BITS;
      sq_i  = (z_i * z_i) >>> FRAC_BITS;
      count = count + 1;
    end
    // A zero limit has no sensible ratio, so it takes the last entry directly.
    if (iter_limit == 0) begin
      idx = PALETTE_SIZE - 1;
    end else begin
      idx = (PALETTE_SIZE * count) / iter_limit;
    end
    if (idx > PALETTE_SIZE - 1) begin
      idx = PALETTE_SIZE - 1;
    end
    res.count  = CNTW'(count);
    res.in_set = (count == iter_limit);
    res.idx    = IDXW'(idx);
    {res.red, res.green, res.blue} = SHADES[idx];
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures = failures + 1;
    end
  endtask

  // One register write per cycle; the caller holds the write enable around it.
  task automatic put_reg(input logic [CFG_AW-1:0] idx, input logic [ZW-1:0] data);
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Writes the whole view back to back. The upper bits of the limit word carry
  // noise, which the block must drop. Junk writes to the spare indexes come last,
  // so an index that aliased onto a real register would show up in the results.
  task automatic program_view(input logic [ZW-1:0] left, input logic [ZW-1:0] top,
                              input logic [ZW-1:0] step_r, input logic [ZW-1:0] step_i,
                              input logic [CNTW-1:0] limit, input bit junk);
    cfg_we_i <= 1'b1;
    put_reg(CFG_LEFT_REAL, left);
    put_reg(CFG_TOP_IMAG, top);
    put_reg(CFG_STEP_REAL, step_r);
    put_reg(CFG_STEP_IMAG, step_i);
    put_reg(CFG_MAX_ITER, {(ZW - CNTW)'($urandom), limit});
    if (junk) begin
      for (int k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++) begin
        put_reg(CFG_AW'(k), $urandom);
      end
    end
    cfg_we_i    <= 1'b0;
    view_left   = left;
    view_top    = top;
    view_step_r = step_r;
    view_step_i = step_i;
    iter_limit  = limit;
  endtask

  // Drops valid and waits until every pixel sent so far has come back. Since each
  // pixel yields exactly one result, the engine is idle from then on.
  task automatic settle();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (offered_results.size() != 0 || awaited_results.size() != 0);
  endtask

  // Offers one pixel beat and returns on the edge where it is taken. Valid stays
  // high after the beat so that back-to-back pixels need no extra assignment.
  task automatic push_pixel(input logic [PIXW-1:0] x, input logic [PIXW-1:0] y,
                            input bit typed, input pixel_res_t typed_res);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered_results.push_back(typed ? typed_res : escape_time(x, y));
    in_valid_i <= 1'b1;
    pixel_x_i  <= x;
    pixel_y_i  <= y;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  initial begin : stimulus
    probe_t      row;
    int          lr;
    int          ti;
    int          sr;
    int          si;
    int unsigned lim;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed probes. The first one runs on the view left by reset.
    for (int i = 0; i < PROBES; i++) begin
      row = PROBE_TAB[i];
      if (row.junk || row.left != view_left || row.top != view_top ||
          row.step_r != view_step_r || row.step_i != view_step_i ||
          row.limit != iter_limit) begin
        settle();
        program_view(row.left, row.top, row.step_r, row.step_i, row.limit, row.junk);
      end
      push_pixel(row.x, row.y, row.typed, row.res);
    end

    // Random phases, each on a freshly drawn view.
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 7))
        0:       lim = 100;
        1:       lim = $urandom_range(1, 4);
        default: lim = $urandom_range(5, 48);
      endcase
      case (PHASE_PLAN[p])
        VIEW_SET: begin
          // Roughly -2.5..-1.0 on the left and -1.5..-0.5 at the top.
          lr = -671088640 + int'($urandom_range(0, 402653184));
          ti = -402653184 + int'($urandom_range(0, 268435456));
          sr = int'($urandom_range(16384, 262144));
          si = int'($urandom_range(16384, 262144));
        end
        VIEW_MIRROR: begin
          lr = 268435456 - int'($urandom_range(0, 268435456));
          ti = 402653184 - int'($urandom_range(0, 268435456));
          sr = -int'($urandom_range(16384, 262144));
          si = -int'($urandom_range(16384, 262144));
        end
        VIEW_NOISE: begin
          lr  = int'($urandom);
          ti  = int'($urandom);
          sr  = int'($urandom);
          si  = int'($urandom);
          lim = $urandom_range(1, 300);
        end
        default: begin
          // The real part stays at 2.0 or more, so no point lingers even with the
          // largest limit.
          lr  = 536870912 + int'($urandom_range(0, 1073741824));
          ti  = int'($urandom);
          sr  = int'($urandom_range(0, 65535));
          si  = int'($urandom);
          lim = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(1, 65535);
        end
      endcase
      settle();
      calm = (p == PHASES - 1);
      program_view(lr, ti, sr, si, CNTW'(lim), 1'b0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_pixel(PIXW'($urandom), PIXW'($urandom), 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failures == 0 && awaited_results.size() == 0) begin
      $display("mandelbrot_escape_time_pixel regression: pass");
    end else begin
      $display("mandelbrot_escape_time_pixel regression: fail");
    end
    $finish;
  end

  // Receiver: short random stalls, plus one long hold-off while the sender keeps
  // offering, so that the output register fills and the input backs up.
  initial begin : sink
    int unsigned stall;
    bit          held;
    stall = 0;
    held  = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && beats_in >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall = stall - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Scoreboard and watchdog. The output side is handled first so that a result
  // arriving on the edge that takes a pixel is never matched against that pixel.
  always @(posedge clk_i) begin : scoreboard
    bit          took_in;
    bit          took_out;
    int unsigned quiet_cycles;
    pixel_res_t  want;
    if (rst_ni) begin
      took_in  = in_valid_i && in_ready_o;
      took_out = out_valid_o && out_ready_i;
      if (took_out) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no pixel outstanding");
          failures = failures + 1;
        end else begin
          want = awaited_results.pop_front();
          check_field("iter_count", want.count, iter_count_o);
          check_field("inside_res", want.in_set, inside_res_o);
          check_field("palette_index", want.idx, palette_index_o);
          check_field("red", want.red, red_o);
          check_field("green", want.green, green_o);
          check_field("blue", want.blue, blue_o);
        end
      end
      if (took_in) begin
        awaited_results.push_back(offered_results.pop_front());
        beats_in = beats_in + 1;
      end
      if (took_in || took_out) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("mandelbrot_escape_time_pixel regression: fail");
          $finish;
        end
      end
    end
  end

endmodule

// ===== sim.f =====
design/mbet_pkg.sv
design/mbet_mul.sv
design/mbet_div.sv
design/mandelbrot_escape_time_pixel.sv
verif/mandelbrot_escape_time_pixel_test.sv
